/* hdl/invc_pkg.sv */
package invc_pkg;

   // Sequence capacity and value width
   localparam int MAX_ITEMS  = 1024;
   localparam int VALUE_BITS = 32;

   // One cell per storable value
   localparam int NUM_CELLS = MAX_ITEMS;

   // Index of a stored value, and per-value count of greater predecessors
   localparam int IDX_W  = $clog2(MAX_ITEMS);
   localparam int CNT_W  = IDX_W;
   // Fill counter must reach MAX_ITEMS itself
   localparam int SEEN_W = $clog2(MAX_ITEMS + 1);

   localparam int SKIP_W = 11;
   localparam int INV_W  = 19;
   localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         last;
   } req_payload_type;

   typedef struct packed {
      logic [INV_W-1:0] inversions;
      logic             overflow;
   } rsp_payload_type;

   // Transaction token marching down the cell chain
   typedef struct packed {
      logic                         valid;
      logic                         store;     // still looking for its own cell
      logic                         last;
      logic                         overflow;
      logic [IDX_W-1:0]             remaining; // cells left before its own cell
      logic [CNT_W-1:0]             count;     // stored values greater than it
      logic signed [VALUE_BITS-1:0] value;
   } token_type;

endpackage

/* hdl/invc_feeder.sv */
module invc_feeder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  invc_pkg::req_payload_type req_payload,
   input  logic [invc_pkg::SKIP_W-1:0] skip_count,
   input  logic                      advance,
   output invc_pkg::token_type       tok_out
);
   import invc_pkg::*;

   logic [SKIP_W-1:0] skipped_ff, skipped_in;
   logic [SEEN_W-1:0] items_seen_ff, items_seen_in;
   logic              overflow_ff, overflow_in;
   token_type         tok_ff, tok_in;

   always_comb begin
      skipped_in        = skipped_ff;
      items_seen_in     = items_seen_ff;
      overflow_in       = overflow_ff;
      tok_in            = '0;
      tok_in.valid      = accept;
      tok_in.last       = req_payload.last;
      tok_in.value      = req_payload.value;
      tok_in.remaining  = items_seen_ff[IDX_W-1:0];
      if (accept) begin
         if (skipped_ff < skip_count) begin
            skipped_in = skipped_ff + SKIP_W'(1);
         end else if (items_seen_ff < SEEN_W'(MAX_ITEMS)) begin
            tok_in.store  = 1'b1;
            items_seen_in = items_seen_ff + SEEN_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
         tok_in.overflow = overflow_in;
         // Clear the sequence once its final item is in
         if (req_payload.last) begin
            skipped_in    = '0;
            items_seen_in = '0;
            overflow_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skipped_ff    <= '0;
         items_seen_ff <= '0;
         overflow_ff   <= 1'b0;
         tok_ff.valid  <= 1'b0;
      end else begin
         skipped_ff    <= skipped_in;
         items_seen_ff <= items_seen_in;
         overflow_ff   <= overflow_in;
         if (advance) begin
            tok_ff <= tok_in;
         end
      end
   end

   assign tok_out = tok_ff;

`ifndef NO_ASSERTIONS
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      items_seen_ff <= SEEN_W'(MAX_ITEMS))
      else $error("fill count beyond capacity");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.last |=>
         items_seen_ff == '0 && skipped_ff == '0 && !overflow_ff)
      else $error("sequence state not cleared after final item");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> items_seen_ff == SEEN_W'(MAX_ITEMS))
      else $error("drop flagged before capacity reached");
`endif

endmodule

/* hdl/invc_cell.sv */
module invc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  invc_pkg::token_type tok_in,
   output invc_pkg::token_type tok_out
);
   import invc_pkg::*;

   logic signed [VALUE_BITS-1:0] stored_ff;
   token_type                    tok_ff, tok_next;
   logic                         active;
   logic                         home;
   logic                         greater;

   assign active  = tok_in.valid && tok_in.store;
   assign home    = active && (tok_in.remaining == '0);
   assign greater = $signed(stored_ff) > $signed(tok_in.value);

   always_comb begin
      tok_next = tok_in;
      if (home) begin
         tok_next.store = 1'b0;
      end else if (active) begin
         tok_next.remaining = tok_in.remaining - IDX_W'(1);
         tok_next.count     = tok_in.count + {{(CNT_W-1){1'b0}}, greater};
      end
   end

   always_ff @(posedge clock) begin
      if (advance && home) begin
         stored_ff <= tok_in.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* hdl/invc_tail.sv */
module invc_tail (
   input  logic                      clock,
   input  logic                      reset,
   input  invc_pkg::token_type       tok_in,
   output logic                      advance,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output invc_pkg::rsp_payload_type rsp_payload
);
   import invc_pkg::*;

   logic [INV_W-1:0] acc_ff, acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff;
   logic [INV_W:0]   sum;
   logic [INV_W-1:0] sum_sat;
   logic             finish;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign sum     = {1'b0, acc_ff} + (INV_W+1)'(tok_in.count);
   assign sum_sat = sum[INV_W] ? INV_MAX : sum[INV_W-1:0];
   assign finish  = advance && tok_in.valid && tok_in.last;

   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = tok_in.valid && tok_in.last;
         if (tok_in.valid) begin
            acc_in = tok_in.last ? '0 : sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_payload_ff.inversions <= sum_sat;
         rsp_payload_ff.overflow   <= tok_in.overflow;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* hdl/inversion_counter.sv */
// The final item's token is registered in the feeder, in every cell of the chain and
//   in the tail before the transaction's result appears on the result channel.
// Throughput: one item per cycle; the whole cell chain advances together and holds
//   only while a finished result waits on the result channel.
// Reset (synchronous, active high) clears skip_count, the sequence counters and all
//   token valid bits; stored cell values are left as they are.
module inversion_counter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  invc_pkg::req_payload_type   req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output invc_pkg::rsp_payload_type   rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [invc_pkg::SKIP_W-1:0] csr_wr_data
);
   import invc_pkg::*;

   // Each accepted item becomes a token. A storing token carries its own index as
   // a countdown; every cell it passes before reaching zero holds an earlier value
   // of the same sequence, so the cell adds one to the token count when its value
   // is strictly greater. The cell where the countdown hits zero keeps the value.
   // Later tokens trail earlier ones, so a cell is always written before any later
   // token of the sequence reads it. Skipped and dropped items travel as
   // non-storing tokens, only to carry the final and overflow flags to the tail.
   // The tail sums token counts per sequence and loads the output register.

   logic [SKIP_W-1:0] skip_count_ff;
   logic              advance;
   logic              accept;
   token_type         tok_chain [0:NUM_CELLS];

   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // Configuration: taken directly, applies from the next item
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_count_ff <= '0;
      end else if (csr_wr_en) begin
         skip_count_ff <= csr_wr_data;
      end
   end

   invc_feeder u_feeder (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .skip_count  (skip_count_ff),
      .advance     (advance),
      .tok_out     (tok_chain[0])
   );

   // Cell chain: one stored value per cell
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      invc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (tok_chain[g]),
         .tok_out (tok_chain[g+1])
      );
   end

   invc_tail u_tail (
      .clock       (clock),
      .reset       (reset),
      .tok_in      (tok_chain[NUM_CELLS]),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
